// ----- rtl/ufds_pkg.sv -----
// Package for the fractional baud divisor search: widths, constants, state enum.
// No dependencies.
`timescale 1ns / 1ps
package ufds_pkg;
	localparam int CLK_W   = 28;
	localparam int PCT_W   = 7;
	localparam int BAUD_W  = 22;
	localparam int DIVR_W  = 16;
	localparam int ERR_W   = 17;
	localparam int NUM_W   = 28;   // width of divisors and remainders in the divider; dividends are four bits wider
	localparam logic [ERR_W-1:0] ERR_INIT = 17'd100000;
	localparam logic [3:0] MUL_MAX = 4'd15;
	localparam logic [3:0] ADD_MAX = 4'd15;
	localparam logic [DIVR_W:0] DIV_MIN = 17'd3;
	localparam logic [6:0] PCT_SCALE = 7'd100;
	localparam int CLK_RST = 25000000;
	localparam int PCT_RST = 3;
	localparam logic [0:0] REG_CLOCK = 1'b0;
	localparam logic [0:0] REG_PCT   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,    // base = m*uclk / (m+a)
		ST_DIV,     // q = base / baud
		ST_RATE,    // rate = base / div
		ST_EVAL,
		ST_NEXT,
		ST_LIM,     // baud*pct / 100
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

// ----- rtl/ufds_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the search sequencer.
// Depends on ufds_pkg.
`timescale 1ns / 1ps
module ufds_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ufds_pkg::NUM_W+4-1:0] dividend,
	input  logic [ufds_pkg::NUM_W-1:0] divisor,
	output ufds_pkg::div_ctl_t ctl,
	output logic [ufds_pkg::NUM_W+4-1:0] quot,
	output logic [ufds_pkg::NUM_W-1:0] rem
);
	import ufds_pkg::*;
	localparam int DW = NUM_W + 4;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [NUM_W-1:0] r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [NUM_W:0] trial;

	assign trial = {r_q, q_q[DW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[NUM_W]) begin
				r_q <= trial[NUM_W-1:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[NUM_W-2:0], q_q[DW-1]};
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign quot = q_q;
	assign rem = r_q;
endmodule

// ----- rtl/uart_fractional_divisor_search.sv -----
// Top level of the fractional baud divisor search: APB registers, sequencer, result stage.
// Depends on ufds_pkg and ufds_divider.
`timescale 1ns / 1ps
// One target baud rate in on s_axis, one best setting out on m_axis. The block walks
// mul 1..15 (outer) and add 0..15 (inner). Every divide state runs on the single
// 32-step restoring divider (launch, 32 steps, collect). A candidate with an in-range divisor
// costs three divides (base, divisor, produced rate) plus an evaluate and a step state;
// one whose divisor falls out of range stops after two divides. An exact match ends the
// search early. The shared divider dominates the search time. s_axis_tready is low from
// acceptance until the result is taken. The limit check (target*accept_pct/100) uses one more
// divider pass. Registers: 0x0 clock_hz, 0x4 accept_pct; write them only while idle.
module uart_fractional_divisor_search (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [21:0] target_baud
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata    // ok, divisor, mul_val, add_val, error_baud
);
	import ufds_pkg::*;
	localparam int DW = NUM_W + 4;

	logic [CLK_W-1:0] clock_q;
	logic [PCT_W-1:0] pct_q;
	state_t st_q, st_d;
	logic [BAUD_W-1:0] baud_q;
	logic [3:0] m_q, a_q, bm_q, ba_q;
	logic [DIVR_W-1:0] bd_q;
	logic [ERR_W-1:0] be_q;
	logic [NUM_W-1:0] base_q;
	logic [DIVR_W:0] div_q;
	logic ok_q, exact_q;

	logic dstart;
	logic [DW-1:0] dnum, quot;
	logic [NUM_W-1:0] dden, rem;
	div_ctl_t dctl;
	logic wr;
	logic [NUM_W-1:0] rate, err;
	logic [NUM_W:0] qplus;

	ufds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dnum), .divisor(dden),
		.ctl(dctl), .quot(quot), .rem(rem)
	);

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PCT) prdata = {25'd0, pct_q};
		else prdata = {4'd0, clock_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLK_W'(CLK_RST);
			pct_q <= PCT_W'(PCT_RST);
		end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_CLOCK) begin
			clock_q <= pwdata[CLK_W-1:0];
		end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_PCT) begin
			pct_q <= pwdata[PCT_W-1:0];
		end
	end

	// divider launches in the cycle the sequencer enters a divide state
	logic launch_q;
	logic first;
	assign first = launch_q;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {6'd0, be_q, ba_q, bm_q, bd_q, ok_q};

	// rate and error from divider output; quotient rounding over the low NUM_W quotient bits
	assign rate = quot[NUM_W-1:0];
	assign err = (rate <= NUM_W'(baud_q)) ? NUM_W'(baud_q) - rate : rate - NUM_W'(baud_q);
	assign qplus = (NUM_W+1)'(quot[NUM_W-1:0]) +
		((rem > NUM_W'(baud_q >> 1)) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));

	always_comb begin
		dstart = 1'b0;
		dnum = '0;
		dden = '0;
		unique case (st_q)
			ST_BASE: begin
				dnum = DW'(m_q) * DW'(clock_q >> 4);
				dden = NUM_W'(m_q) + NUM_W'(a_q);
				dstart = first;
			end
			ST_DIV: begin
				dnum = DW'(base_q);
				dden = NUM_W'(baud_q);
				dstart = first;
			end
			ST_RATE: begin
				dnum = DW'(base_q);
				dden = NUM_W'(div_q);
				dstart = first;
			end
			ST_LIM: begin
				dnum = DW'(baud_q) * DW'(pct_q);
				dden = NUM_W'(PCT_SCALE);
				dstart = first;
			end
			default: ;
		endcase
	end

	logic ddone;
	assign ddone = !first && !dctl.busy;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (s_axis_tvalid)
				st_d = (s_axis_tdata[BAUD_W-1:0] == '0) ? ST_LIM : ST_BASE;
			ST_BASE: if (ddone) st_d = ST_DIV;
			ST_DIV: if (ddone)
				st_d = (qplus < (NUM_W+1)'(DIV_MIN) ||
					qplus > (NUM_W+1)'({DIVR_W{1'b1}})) ? ST_NEXT : ST_RATE;
			ST_RATE: if (ddone) st_d = ST_EVAL;
			ST_EVAL: st_d = ST_NEXT;
			ST_NEXT: begin
				if (exact_q || (m_q == MUL_MAX && a_q == ADD_MAX)) st_d = ST_LIM;
				else st_d = ST_BASE;
			end
			ST_LIM: if (ddone) st_d = ST_OUT;
			ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			st_q <= st_d;
			launch_q <= (st_d != st_q) &&
				(st_d == ST_BASE || st_d == ST_DIV || st_d == ST_RATE || st_d == ST_LIM);
		end
	end

	logic [NUM_W-1:0] err_s1;
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (s_axis_tvalid) begin
				baud_q <= s_axis_tdata[BAUD_W-1:0];
				m_q <= 4'd1; a_q <= 4'd0;
				bm_q <= 4'd1; ba_q <= 4'd0; bd_q <= '0; be_q <= ERR_INIT;
				exact_q <= 1'b0;
			end
			ST_BASE: if (ddone) base_q <= quot[NUM_W-1:0];
			ST_DIV: if (ddone) div_q <= qplus[DIVR_W:0];
			ST_RATE: if (ddone) err_s1 <= err;
			ST_EVAL: if (err_s1 < NUM_W'(be_q)) begin
				be_q <= err_s1[ERR_W-1:0];
				bd_q <= div_q[DIVR_W-1:0];
				bm_q <= m_q; ba_q <= a_q;
				exact_q <= (err_s1 == '0);
			end
			ST_NEXT: begin
				a_q <= a_q + 4'd1;
				if (a_q == ADD_MAX) m_q <= m_q + 4'd1;
			end
			ST_LIM: if (ddone) ok_q <= (NUM_W'(be_q) < quot[NUM_W-1:0]);
			default: ;
		endcase
	end
endmodule

// ----- rtl/ufds_checker.sv -----
// Port-level checker for the divisor search, bound to the top level.
// Depends on uart_fractional_divisor_search ports only.
`timescale 1ns / 1ps
module ufds_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after beat");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16:1] == 16'd0 |->
		m_axis_tdata[41:25] == 17'd100000 && m_axis_tdata[20:17] == 4'd1)
		else $error("bad defaults");
endmodule

bind uart_fractional_divisor_search ufds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ----- dv/uart_fractional_divisor_search_tb.sv -----
// Testbench for uart_fractional_divisor_search: target baud rates in on the stream slave,
// best fractional divider settings checked against an in-bench search. Needs ufds_pkg and the RTL.
`timescale 1ns / 1ps
module uart_fractional_divisor_search_tb;
	import ufds_pkg::*;

	localparam logic [2:0] ADDR_CLOCK = 3'd0;
	localparam logic [2:0] ADDR_PCT   = 3'd4;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD = 3000;

	typedef struct packed {
		logic [ERR_W-1:0] error_baud;
		logic [3:0] add_val;
		logic [3:0] mul_val;
		logic [DIVR_W-1:0] divisor;
		logic ok;
	} setting_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [23:0] s_axis_tdata;   // [21:0] target_baud
	logic [47:0] m_axis_tdata;   // [0] ok, [16:1] divisor, [20:17] mul, [24:21] add, [41:25] err

	uart_fractional_divisor_search DUT (.*);

	// register mirror, updated as each write lands
	logic [CLK_W-1:0] clock_mirror;
	logic [PCT_W-1:0] pct_mirror;

	logic [BAUD_W-1:0] pending_bauds[$];
	setting_t expected_settings[$];
	int mismatches, n_in, n_out, n_fail_searches, watchdog;
	bit in_taken, out_taken, calm, hold_req;
	int send_gap, recv_stall;

	// walks the (mul, add) pairs until an exact match and keeps the best divisor
	function automatic setting_t search_best(logic [BAUD_W-1:0] baud,
			logic [CLK_W-1:0] clock_hz, logic [PCT_W-1:0] pct);
		setting_t r;
		longint unsigned uclk, best_err, base, dv, rate, err_v;
		bit exact;
		uclk = clock_hz >> 4;
		best_err = ERR_INIT;
		exact = 0;
		r = '0;
		r.mul_val = 4'd1;
		if (baud != 0) begin
			for (int m = 1; m <= MUL_MAX && !exact; m++) begin
				for (int a = 0; a <= ADD_MAX && !exact; a++) begin
					base = (m * uclk) / (m + a);
					dv = base / baud;
					if ((base % baud) > (baud / 2)) dv++;
					if (dv < DIV_MIN || dv >= 65536) continue;
					rate = base / dv;
					err_v = (rate <= baud) ? baud - rate : rate - baud;
					if (err_v < best_err) begin
						best_err = err_v;
						r.divisor = dv[DIVR_W-1:0];
						r.mul_val = m[3:0];
						r.add_val = a[3:0];
						if (err_v == 0) exact = 1;
					end
				end
			end
		end
		r.error_baud = best_err[ERR_W-1:0];
		r.ok = best_err < ((longint'(baud) * pct) / PCT_SCALE);
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// input side: beat leaves at the falling edge after acceptance, then a random gap
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			send_gap = 0;
		end else if (in_taken) begin
			in_taken = 0;
			s_axis_tvalid <= 0;
			send_gap = calm ? 0 : $urandom_range(0, 18);
		end else if (!s_axis_tvalid) begin
			if (send_gap > 0) send_gap--;
			else if (pending_bauds.size() > 0) begin
				s_axis_tdata <= {2'b00, pending_bauds.pop_front()};
				s_axis_tvalid <= 1;
			end
		end
	end

	// output side: random stall per beat, one long hold on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			recv_stall = 0;
		end else if (out_taken) begin
			out_taken = 0;
			m_axis_tready <= 0;
			if (hold_req) begin
				hold_req = 0;
				recv_stall = LONG_HOLD;
			end else recv_stall = calm ? 0 : $urandom_range(0, 18);
		end else if (recv_stall > 0) recv_stall--;
		else m_axis_tready <= 1;
	end

	// monitor: predict on input beats, compare on output beats
	always @(posedge clk) begin
		setting_t got, exp_s;
		if (arst_n) begin
			watchdog++;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_settings.push_back(search_best(s_axis_tdata[BAUD_W-1:0],
					clock_mirror, pct_mirror));
				in_taken = 1;
				n_in++;
				watchdog = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[41:0];
				out_taken = 1;
				n_out++;
				watchdog = 0;
				if (expected_settings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
				end else begin
					exp_s = expected_settings.pop_front();
					if (!exp_s.ok) n_fail_searches++;
					if (got.ok !== exp_s.ok || got.divisor !== exp_s.divisor ||
							got.mul_val !== exp_s.mul_val || got.add_val !== exp_s.add_val ||
							got.error_baud !== exp_s.error_baud) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch beat %0d: exp ok=%0d div=%0d mul=%0d add=%0d err=%0d",
								n_out, exp_s.ok, exp_s.divisor, exp_s.mul_val, exp_s.add_val,
								exp_s.error_baud);
							$display("  got ok=%0d div=%0d mul=%0d add=%0d err=%0d",
								got.ok, got.divisor, got.mul_val, got.add_val, got.error_baud);
						end
					end
				end
			end
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("[uart_fractional_divisor_search] ERROR");
				$finish;
			end
		end
	end

	// two-phase register write, only while idle
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		if (addr == ADDR_CLOCK) clock_mirror = value[CLK_W-1:0];
		else pct_mirror = value[PCT_W-1:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// checked at rising edges so a beat being loaded is never missed
	task automatic drain();
		while (pending_bauds.size() != 0 || expected_settings.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// half standard rates, the rest anywhere in the 22-bit field
	task automatic queue_random(int count);
		int common_rates[14] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
			115200, 230400, 460800, 921600, 1000000, 3000000};
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0, 1: pending_bauds.push_back(BAUD_W'(common_rates[$urandom_range(0, 13)]));
				2: pending_bauds.push_back(BAUD_W'($urandom_range(1, 4000000)));
				default: pending_bauds.push_back(BAUD_W'($urandom_range(0, 4194303)));
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		clock_mirror = CLK_W'(CLK_RST);
		pct_mirror = PCT_W'(PCT_RST);
		mismatches = 0; n_in = 0; n_out = 0; n_fail_searches = 0; watchdog = 0;
		in_taken = 0; out_taken = 0; calm = 0; hold_req = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: field extremes, zero target, the reset clock over 16 (25 MHz / 16), bit patterns
		pending_bauds = '{22'd0, 22'd1, 22'h3FFFFF, 22'd4000000, 22'd1562500, 22'd115200,
			22'd9600, 22'd300, 22'h2AAAAA, 22'h155555, 22'd3000000};
		hold_req = 1;   // receiver sits on one result while inputs queue up
		drain();

		// fast clock, loose acceptance
		write_reg(ADDR_CLOCK, 200000000);
		write_reg(ADDR_PCT, 100);
		pending_bauds = '{22'd4000000, 22'd1, 22'd1562500};
		queue_random(20);
		drain();

		// clock of one hertz: nothing valid; zero acceptance
		write_reg(ADDR_CLOCK, 1);
		write_reg(ADDR_PCT, 0);
		pending_bauds = '{22'd9600, 22'd1};
		queue_random(8);
		drain();

		// zero clock, and full register width with acceptance beyond a hundred
		write_reg(ADDR_CLOCK, 0);
		pending_bauds = '{22'd115200};
		drain();
		write_reg(ADDR_CLOCK, 32'h0FFFFFFF);
		write_reg(ADDR_PCT, 127);
		calm = 1;
		queue_random(25);
		drain();
		calm = 0;

		write_reg(ADDR_CLOCK, 12000000);
		write_reg(ADDR_PCT, 3);
		queue_random(25);
		drain();

		write_reg(ADDR_CLOCK, CLK_RST);
		write_reg(ADDR_PCT, 5);
		queue_random(20);
		drain();

		$display("covered %0d target rates over seven clock/acceptance settings,", n_in);
		$display("%0d results checked, %0d of them rejected searches", n_out, n_fail_searches);
		if (mismatches == 0 && expected_settings.size() == 0)
			$display("[uart_fractional_divisor_search] OK");
		else
			$display("[uart_fractional_divisor_search] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/ufds_pkg.sv
rtl/ufds_divider.sv
rtl/uart_fractional_divisor_search.sv
rtl/ufds_checker.sv
dv/uart_fractional_divisor_search_tb.sv
